// ----- rtl/psfl_pkg.sv -----
// Shared types and constants of the per-source flood limiter.
package psfl_pkg;

  localparam int unsigned TABLE_ENTRIES = 128;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned KEY_W = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned REL_W = 8;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD = 2'd2;

  localparam logic [CFG_W-1:0] RATE_LIMIT_RST = 16'd5;
  localparam logic [CFG_W-1:0] WINDOW_RST = 16'd10;
  localparam logic [CFG_W-1:0] HOLD_RST = 16'd60;

  localparam logic CMD_MESSAGE = 1'b0;
  localparam logic CMD_SWEEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_ADD,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    logic [COUNT_W-1:0] count;
    logic               ignored;
    logic               notified;
  } entry_t;

  typedef struct packed {
    logic [REL_W-1:0] released;
    logic             added;
    logic             notice;
    logic             blocked;
  } result_t;

endpackage

// ----- rtl/psfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module psfl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/per_source_flood_limiter_top.sv -----
// Per-source flood limiter: source table, scan sequencer and result register.
//
// Input items arrive on the s_axis channel: tuser holds the command (message or
// release sweep), tdata holds the source key and the current time in seconds.
// Each item gives exactly one result item on m_axis, carrying the blocked,
// notice and new-source flags and the number of sources a sweep released.
// The source table lives in one RAM; a single read port is walked one entry
// per cycle, and one subtract-and-compare unit checks each entry's age.
// A message scan stops at the first key match; a sweep walks every used entry.
// The block takes one item at a time: s_axis_tready is high only between items.
// The result sits in an output register; a new item is accepted while it waits,
// and only the finishing step of that next item waits for the register to free.
// Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
// while the block is idle, a rule for the user that the block does not enforce.
// Reset empties the table (entries_used = 0), loads the register defaults and
// drops any pending result; the RAM needs no clearing.
module per_source_flood_limiter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // source_key [31:0], now_seconds [63:32]
  input  logic [63:0]                   s_axis_tdata,
  // cmd [0]
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // blocked [0], send_notice [1], new_source [2], released [10:3], zero fill
  output logic [15:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [psfl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psfl_pkg::CFG_W-1:0]    cfg_data_i
);

  psfl_pkg::state_e state_q, state_d;

  logic [psfl_pkg::CFG_W-1:0]   rate_q, window_q, hold_q;
  logic [psfl_pkg::USED_W-1:0]  used_q, used_d;
  logic [psfl_pkg::USED_W-1:0]  idx_q, idx_d;
  logic                         pend_q, pend_d;
  logic [psfl_pkg::IDX_W-1:0]   pend_idx_q;
  logic                         cmd_q;
  logic [psfl_pkg::KEY_W-1:0]   key_q;
  logic [psfl_pkg::STAMP_W-1:0] now_q;
  psfl_pkg::entry_t             hit_q;
  logic [psfl_pkg::IDX_W-1:0]   hit_idx_q;
  logic                         hit_gap_q;
  logic [psfl_pkg::REL_W-1:0]   rel_q, rel_d;
  psfl_pkg::result_t            res_q, res_d;
  logic                         m_valid_q, m_valid_d;
  psfl_pkg::result_t            m_data_q;

  logic                         in_acc;
  logic                         issue;
  logic                         hit;
  logic                         rel_hit;
  logic                         scan_done;
  logic                         out_free;
  logic [psfl_pkg::STAMP_W-1:0] gap;
  logic [psfl_pkg::CFG_W-1:0]   thr;
  logic                         gap_gt;
  logic [psfl_pkg::COUNT_W-1:0] count_inc;

  logic                         ram_we, ram_re;
  logic [psfl_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
  psfl_pkg::entry_t             ram_wdata, ram_rdata;

  psfl_ram #(
    .Width ($bits(psfl_pkg::entry_t)),
    .Depth (psfl_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == psfl_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Shared age unit: elapsed time against the window or the hold time.
  assign thr = (cmd_q == psfl_pkg::CMD_SWEEP) ? hold_q : window_q;
  assign gap = now_q - ram_rdata.stamp;
  assign gap_gt = gap > psfl_pkg::STAMP_W'(thr);

  assign issue = (state_q == psfl_pkg::ST_SCAN) && (idx_q < used_q);
  assign hit = (state_q == psfl_pkg::ST_SCAN) && pend_q &&
               (cmd_q == psfl_pkg::CMD_MESSAGE) && (ram_rdata.key == key_q);
  assign rel_hit = (state_q == psfl_pkg::ST_SCAN) && pend_q &&
                   (cmd_q == psfl_pkg::CMD_SWEEP) && ram_rdata.ignored && gap_gt;
  assign scan_done = (state_q == psfl_pkg::ST_SCAN) && !issue && !pend_q;

  assign count_inc = (hit_q.count == '1) ? hit_q.count : hit_q.count + 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      psfl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = psfl_pkg::ST_SCAN;
        end
      end
      psfl_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = psfl_pkg::ST_UPD;
        end else if (scan_done) begin
          state_d = (cmd_q == psfl_pkg::CMD_SWEEP) ? psfl_pkg::ST_RESP : psfl_pkg::ST_ADD;
        end
      end
      psfl_pkg::ST_UPD: state_d = psfl_pkg::ST_RESP;
      psfl_pkg::ST_ADD: state_d = psfl_pkg::ST_RESP;
      psfl_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = psfl_pkg::ST_IDLE;
        end
      end
      default: state_d = psfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pend_idx_q;
    ram_wdata = ram_rdata;
    ram_re = issue;
    ram_raddr = idx_q[psfl_pkg::IDX_W-1:0];
    used_d = used_q;
    idx_d = idx_q;
    pend_d = 1'b0;
    rel_d = rel_q;
    res_d = res_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    case (state_q)
      psfl_pkg::ST_IDLE: begin
        idx_d = '0;
        rel_d = '0;
        res_d = '0;
      end
      psfl_pkg::ST_SCAN: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        pend_d = issue && !hit;
        if (rel_hit) begin
          ram_we = 1'b1;
          ram_wdata.stamp = now_q;
          ram_wdata.count = '0;
          ram_wdata.ignored = 1'b0;
          ram_wdata.notified = 1'b0;
          if (rel_q != '1) begin
            rel_d = rel_q + 1'b1;
          end
        end
        if (scan_done) begin
          res_d.released = rel_q;
        end
      end
      psfl_pkg::ST_UPD: begin
        ram_waddr = hit_idx_q;
        ram_wdata = hit_q;
        if (hit_q.ignored) begin
          res_d.blocked = 1'b1;
        end else begin
          ram_we = 1'b1;
          ram_wdata.count = count_inc;
          if (hit_gap_q) begin
            ram_wdata.count = '0;
            ram_wdata.stamp = now_q;
          end else if (count_inc >= rate_q) begin
            ram_wdata.ignored = 1'b1;
            ram_wdata.notified = 1'b1;
            res_d.notice = !hit_q.notified;
            res_d.blocked = 1'b1;
          end else begin
            ram_wdata.stamp = now_q;
          end
        end
      end
      psfl_pkg::ST_ADD: begin
        // A full table starts over at slot 0 and forgets the older entries.
        ram_we = 1'b1;
        if (used_q == psfl_pkg::USED_W'(psfl_pkg::TABLE_ENTRIES)) begin
          ram_waddr = '0;
          used_d = psfl_pkg::USED_W'(1);
        end else begin
          ram_waddr = used_q[psfl_pkg::IDX_W-1:0];
          used_d = used_q + 1'b1;
        end
        ram_wdata.key = key_q;
        ram_wdata.stamp = now_q;
        ram_wdata.count = '0;
        ram_wdata.ignored = 1'b0;
        ram_wdata.notified = 1'b0;
        res_d.added = 1'b1;
      end
      psfl_pkg::ST_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
        end
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psfl_pkg::ST_IDLE;
      used_q <= '0;
      pend_q <= 1'b0;
      m_valid_q <= 1'b0;
      rate_q <= psfl_pkg::RATE_LIMIT_RST;
      window_q <= psfl_pkg::WINDOW_RST;
      hold_q <= psfl_pkg::HOLD_RST;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      pend_q <= pend_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psfl_pkg::REG_RATE_LIMIT: rate_q <= cfg_data_i;
          psfl_pkg::REG_WINDOW:     window_q <= cfg_data_i;
          psfl_pkg::REG_HOLD:       hold_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rel_q <= rel_d;
    res_q <= res_d;
    pend_idx_q <= idx_q[psfl_pkg::IDX_W-1:0];
    if (in_acc) begin
      cmd_q <= s_axis_tuser[0];
      key_q <= s_axis_tdata[31:0];
      now_q <= s_axis_tdata[63:32];
    end
    if (hit) begin
      hit_q <= ram_rdata;
      hit_idx_q <= pend_idx_q;
      hit_gap_q <= gap_gt;
    end
    if (state_q == psfl_pkg::ST_RESP && out_free) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = {5'b0, m_data_q};

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= psfl_pkg::USED_W'(psfl_pkg::TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == psfl_pkg::ST_SCAN && !pend_q)
    else $error("accepted item did not start a scan");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q != psfl_pkg::ST_IDLE && state_q != psfl_pkg::ST_RESP)
    else $error("table written outside an item");

  a_new_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> used_q != '0)
    else $error("new source reported with an empty table");
`endif

endmodule
